// ===== sv/dqsv_pkg.sv =====
// Package with types and constants shared by the dq to SVPWM duty block.
`default_nettype none
package dqsv_pkg;

    localparam int FRAC_BITS = 15;

    localparam int IN_W    = 16;
    localparam int PER_W   = 16;
    localparam int PROD_W  = 2 * IN_W;
    localparam int SUM_W   = PROD_W + 1;
    localparam int AB_W    = SUM_W + 1 - FRAC_BITS;
    localparam int K_W     = 32;
    localparam int K_FRAC  = 30;
    localparam int PB_W    = AB_W + K_W;
    localparam int S_W     = AB_W + 1;
    localparam int U_W     = AB_W + 2;
    localparam int W_W     = U_W + 2;
    localparam int M_W     = W_W + K_W;
    localparam int D_SH    = FRAC_BITS + 2;
    localparam int DW      = (M_W + 1 > K_FRAC + 2) ? M_W + 1 : K_FRAC + 2;
    localparam int DUTY_W  = K_FRAC + 1;
    localparam int CMP_W   = DUTY_W + PER_W;
    localparam int PHASES  = 3;

    localparam int B_STAGES = 10;
    localparam int LATENCY  = B_STAGES + 2;

    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    localparam logic [PER_W-1:0] PERIOD_RESET = 16'd100;

    localparam logic signed [K_W-1:0] SQRT3_K = 32'sd1859775393;
    localparam logic signed [K_W-1:0] INV_K   = 32'sd619925131;

    localparam logic signed [SUM_W-1:0] RND_AB = SUM_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [PB_W-1:0]  RND_S  = PB_W'(1) << (K_FRAC - 1);
    localparam logic signed [M_W-1:0]   RND_D  = M_W'(1) << (D_SH - 1);
    localparam logic signed [DW-1:0]    HALF_D = DW'(1) << (K_FRAC - 1);
    localparam logic signed [DW-1:0]    ONE_D  = DW'(1) << K_FRAC;
    localparam logic [DUTY_W-1:0]       ONE_U  = DUTY_W'(1) << K_FRAC;

    typedef struct packed {
        logic signed [IN_W-1:0] d_voltage;
        logic signed [IN_W-1:0] q_voltage;
        logic signed [IN_W-1:0] sine_value;
        logic signed [IN_W-1:0] cosine_value;
    } t_dq_cmd;

    typedef struct packed {
        logic [PER_W-1:0] duty_a;
        logic [PER_W-1:0] duty_b;
        logic [PER_W-1:0] duty_c;
        logic             clipped;
    } t_duty_res;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage
`default_nettype wire

// ===== sv/dqsv_front.sv =====
// Front end that takes command requests and hands them to the queue.
`default_nettype none
module dqsv_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire dqsv_pkg::t_dq_cmd  i_cmd,
    input  wire dqsv_pkg::t_q_status i_q_stat,
    output logic                    o_push,
    output dqsv_pkg::t_dq_cmd       o_cmd
);
    import dqsv_pkg::*;

    logic    r_valid, n_valid;
    t_dq_cmd r_cmd, n_cmd;
    logic    accept;

    always_comb begin
        o_push  = r_valid && !i_q_stat.full;
        busy    = r_valid && i_q_stat.full;
        accept  = start && !busy;
        n_valid = accept || (r_valid && !o_push);
        n_cmd   = accept ? i_cmd : r_cmd;
        o_cmd   = r_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_cmd <= n_cmd;
    end

endmodule
`default_nettype wire

// ===== sv/dqsv_queue.sv =====
// Small command queue between the front end and the datapath.
`default_nettype none
module dqsv_queue (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_push,
    input  wire dqsv_pkg::t_dq_cmd   i_cmd,
    input  wire logic                i_pop,
    output dqsv_pkg::t_dq_cmd        o_cmd,
    output dqsv_pkg::t_q_status      o_stat
);
    import dqsv_pkg::*;

    t_dq_cmd          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [Q_AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [Q_AW:0]    r_count, n_count;
    logic             do_push, do_pop;

    always_comb begin
        o_stat.full  = (r_count == (Q_AW+1)'(Q_DEPTH));
        o_stat.empty = (r_count == '0);
        do_push      = i_push && !o_stat.full;
        do_pop       = i_pop && !o_stat.empty;
        n_wr_ptr     = do_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr     = do_pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count      = r_count + (Q_AW+1)'(do_push) - (Q_AW+1)'(do_pop);
        o_cmd        = r_mem[r_rd_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule
`default_nettype wire

// ===== sv/dqsv_back.sv =====
// Pipelined datapath: inverse Park, min-max injection, duty scaling and clamping.
`default_nettype none
module dqsv_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_vld,
    input  wire dqsv_pkg::t_dq_cmd             i_cmd,
    input  wire logic [dqsv_pkg::PER_W-1:0]    i_period,
    output logic                               o_vld,
    output dqsv_pkg::t_duty_res                o_res
);
    import dqsv_pkg::*;

    logic [B_STAGES-1:0] r_vld;

    logic signed [PROD_W-1:0] r_p_dc, r_p_qs, r_p_ds, r_p_qc;
    logic signed [PROD_W-1:0] n_p_dc, n_p_qs, n_p_ds, n_p_qc;
    logic signed [SUM_W-1:0]  sum_a, sum_b;
    logic signed [AB_W-1:0]   r_alpha2, r_beta2, n_alpha2, n_beta2;
    logic signed [AB_W-1:0]   r_alpha3;
    logic signed [PB_W-1:0]   r_bk, n_bk;
    logic signed [S_W-1:0]    s_val;
    logic signed [U_W-1:0]    r_u4 [PHASES];
    logic signed [U_W-1:0]    n_u4 [PHASES];
    logic signed [U_W-1:0]    r_u5 [PHASES];
    logic signed [U_W-1:0]    u_max, u_min;
    logic signed [W_W-1:0]    r_mm, n_mm;
    logic signed [W_W-1:0]    r_w [PHASES];
    logic signed [W_W-1:0]    n_w [PHASES];
    logic signed [M_W-1:0]    r_m [PHASES];
    logic signed [M_W-1:0]    n_m [PHASES];
    logic signed [DW-1:0]     duty_raw [PHASES];
    logic [DUTY_W-1:0]        r_duty [PHASES];
    logic [DUTY_W-1:0]        n_duty [PHASES];
    logic [PHASES-1:0]        clip_v;
    logic                     r_clip8, r_clip9;
    logic [CMP_W-1:0]         r_cmp [PHASES];
    logic [CMP_W-1:0]         n_cmp [PHASES];
    t_duty_res                r_res, n_res;

    always_comb begin
        n_p_dc = $signed(i_cmd.d_voltage) * $signed(i_cmd.cosine_value);
        n_p_qs = $signed(i_cmd.q_voltage) * $signed(i_cmd.sine_value);
        n_p_ds = $signed(i_cmd.d_voltage) * $signed(i_cmd.sine_value);
        n_p_qc = $signed(i_cmd.q_voltage) * $signed(i_cmd.cosine_value);

        sum_a    = SUM_W'(r_p_dc) - SUM_W'(r_p_qs) + RND_AB;
        sum_b    = SUM_W'(r_p_ds) + SUM_W'(r_p_qc) + RND_AB;
        n_alpha2 = AB_W'(sum_a >>> FRAC_BITS);
        n_beta2  = AB_W'(sum_b >>> FRAC_BITS);

        n_bk = r_beta2 * SQRT3_K;

        s_val   = S_W'((r_bk + RND_S) >>> K_FRAC);
        n_u4[0] = U_W'(r_alpha3) <<< 1;
        n_u4[1] = U_W'(s_val) - U_W'(r_alpha3);
        n_u4[2] = -U_W'(s_val) - U_W'(r_alpha3);

        u_max = r_u4[0];
        u_min = r_u4[0];
        for (int i = 1; i < PHASES; i++) begin
            if (r_u4[i] > u_max) begin
                u_max = r_u4[i];
            end
            if (r_u4[i] < u_min) begin
                u_min = r_u4[i];
            end
        end
        n_mm = W_W'(u_max) + W_W'(u_min);

        for (int i = 0; i < PHASES; i++) begin
            n_w[i] = (W_W'(r_u5[i]) <<< 1) - r_mm;
            n_m[i] = r_w[i] * INV_K;
            duty_raw[i] = DW'((r_m[i] + RND_D) >>> D_SH) + HALF_D;
            if (duty_raw[i][DW-1]) begin
                n_duty[i] = '0;
                clip_v[i] = 1'b1;
            end else if (duty_raw[i] > ONE_D) begin
                n_duty[i] = ONE_U;
                clip_v[i] = 1'b1;
            end else begin
                n_duty[i] = DUTY_W'(duty_raw[i]);
                clip_v[i] = 1'b0;
            end
            n_cmp[i] = CMP_W'(r_duty[i]) * CMP_W'(i_period);
        end

        n_res.duty_a  = r_cmp[0][K_FRAC +: PER_W];
        n_res.duty_b  = r_cmp[1][K_FRAC +: PER_W];
        n_res.duty_c  = r_cmp[2][K_FRAC +: PER_W];
        n_res.clipped = r_clip9;

        o_vld = r_vld[B_STAGES-1];
        o_res = r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[B_STAGES-2:0], i_vld};
        end
        r_p_dc   <= n_p_dc;
        r_p_qs   <= n_p_qs;
        r_p_ds   <= n_p_ds;
        r_p_qc   <= n_p_qc;
        r_alpha2 <= n_alpha2;
        r_beta2  <= n_beta2;
        r_alpha3 <= r_alpha2;
        r_bk     <= n_bk;
        r_mm     <= n_mm;
        for (int i = 0; i < PHASES; i++) begin
            r_u4[i]   <= n_u4[i];
            r_u5[i]   <= r_u4[i];
            r_w[i]    <= n_w[i];
            r_m[i]    <= n_m[i];
            r_duty[i] <= n_duty[i];
            r_cmp[i]  <= n_cmp[i];
        end
        r_clip8 <= |clip_v;
        r_clip9 <= r_clip8;
        r_res   <= n_res;
    end

endmodule
`default_nettype wire

// ===== sv/dq_to_svpwm_duty.sv =====
// Top level of the dq voltage command to SVPWM compare value block.
// A command request is taken whenever start is high and busy is low, one per
// clock cycle without gaps, and its three compare values and clip flag appear
// on o_res with o_done high for a single cycle. Their path runs through the
// input register, the command queue and the ten stage datapath, where each
// stage holds at most one rank of multipliers. The receiver cannot stall, so
// results leave at the rate requests arrive and busy stays low in normal use.
// The period register resets to 100 and is written through the cfg channel,
// which is always ready.
`default_nettype none
module dq_to_svpwm_duty (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire dqsv_pkg::t_dq_cmd             i_cmd,
    output dqsv_pkg::t_duty_res                o_res,
    output logic                               o_done,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [dqsv_pkg::PER_W-1:0]    i_cfg_data
);
    import dqsv_pkg::*;

    logic [PER_W-1:0] r_pwm_period, n_pwm_period;
    t_q_status        q_stat;
    logic             front_push;
    t_dq_cmd          front_cmd;
    t_dq_cmd          q_cmd;
    logic             q_pop;

    always_comb begin
        o_cfg_ready  = 1'b1;
        n_pwm_period = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_pwm_period;
        q_pop        = !q_stat.empty;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_period <= PERIOD_RESET;
        end else begin
            r_pwm_period <= n_pwm_period;
        end
    end

    dqsv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .i_q_stat (q_stat),
        .o_push   (front_push),
        .o_cmd    (front_cmd)
    );

    dqsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_cmd),
        .o_stat  (q_stat)
    );

    dqsv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (q_pop),
        .i_cmd    (q_cmd),
        .i_period (r_pwm_period),
        .o_vld    (o_done),
        .o_res    (o_res)
    );

    // Every result must come from a request that was taken earlier.
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LATENCY))
        else $error("result without a matching request");

    // The datapath never stalls, so the queue must never fill up.
    a_queue_never_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !q_stat.full)
        else $error("command queue filled up");

    // A request leaves the queue in the cycle after it was pushed.
    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        front_push |=> q_pop)
        else $error("queue did not hand a request to the datapath");

endmodule
`default_nettype wire

// ===== tb/tb_dq_to_svpwm_duty.sv =====
// Self-checking testbench for the dq to SVPWM compare value block.
module tb_dq_to_svpwm_duty;

    import dqsv_pkg::*;

    localparam int     LIMIT_CYCLES  = 200000;
    localparam int     LATENCY_SLACK = 16;
    localparam int     PHASE_COUNT   = 6;
    localparam int     PHASE_ITEMS   = 134;
    localparam longint ROOT3_Q30     = 64'sd1859775393;
    localparam longint INV_ROOT3_Q30 = 64'sd619925131;
    localparam longint UNIT_DUTY     = 64'sd1 <<< 30;
    localparam real    TWO_PI        = 6.283185307179586;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              start       = 1'b0;
    logic              busy;
    t_dq_cmd           i_cmd       = '0;
    t_duty_res         o_res;
    logic              o_done;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [PER_W-1:0]  i_cfg_data  = '0;

    t_dq_cmd           cmd_backlog[$];
    t_duty_res         duty_expected[$];
    logic [PER_W-1:0]  period_now    = PERIOD_RESET;
    logic              cmd_taken     = 1'b0;
    logic              all_drained   = 1'b0;
    bit                drain_hold    = 1'b0;
    int                idle_pct      = 0;
    int                issued_count  = 0;
    int                accepted_count = 0;
    int                result_count  = 0;
    int                clip_count    = 0;
    int                period_writes = 0;
    int                mismatch_count = 0;
    int                cycle_count   = 0;

    dq_to_svpwm_duty i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res       (o_res),
        .o_done      (o_done),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint round_shift(longint x, int n);
        return (x + (longint'(1) <<< (n - 1))) >>> n;
    endfunction

    function automatic logic [PER_W-1:0] phase_compare(longint w, logic [PER_W-1:0] per,
                                                       inout bit clip);
        longint duty;
        longint scaled;
        duty = round_shift(w * INV_ROOT3_Q30, FRAC_BITS + 2) + UNIT_DUTY / 2;
        if (duty < 0) begin
            duty = 0;
            clip = 1'b1;
        end else if (duty > UNIT_DUTY) begin
            duty = UNIT_DUTY;
            clip = 1'b1;
        end
        scaled = (duty * longint'(per)) >>> 30;
        return scaled[PER_W-1:0];
    endfunction

    function automatic t_duty_res predict_duty(t_dq_cmd c, logic [PER_W-1:0] per);
        longint d, q, sn, cs, alpha, beta, s, ua, ub, uc, mx, mn;
        bit clip;
        t_duty_res r;
        d = longint'($signed(c.d_voltage));
        q = longint'($signed(c.q_voltage));
        sn = longint'($signed(c.sine_value));
        cs = longint'($signed(c.cosine_value));
        alpha = round_shift(d * cs - q * sn, FRAC_BITS);
        beta = round_shift(d * sn + q * cs, FRAC_BITS);
        s = round_shift(beta * ROOT3_Q30, 30);
        ua = 2 * alpha;
        ub = s - alpha;
        uc = -s - alpha;
        mx = ua;
        mn = ua;
        if (ub > mx) mx = ub;
        if (uc > mx) mx = uc;
        if (ub < mn) mn = ub;
        if (uc < mn) mn = uc;
        clip = 1'b0;
        r.duty_a = phase_compare(2 * ua - mx - mn, per, clip);
        r.duty_b = phase_compare(2 * ub - mx - mn, per, clip);
        r.duty_c = phase_compare(2 * uc - mx - mn, per, clip);
        r.clipped = clip;
        return r;
    endfunction

    function automatic logic signed [IN_W-1:0] sat_q15(real x);
        if (x > 32767.0) return 16'sh7fff;
        if (x < -32768.0) return 16'sh8000;
        return 16'($rtoi(x));
    endfunction

    function automatic t_dq_cmd make_cmd(int d, int q, int sn, int cs);
        t_dq_cmd c;
        c.d_voltage = 16'(d);
        c.q_voltage = 16'(q);
        c.sine_value = 16'(sn);
        c.cosine_value = 16'(cs);
        return c;
    endfunction

    // Most commands are a rotating vector of random length at a random angle;
    // the rest are raw codes.
    function automatic t_dq_cmd random_cmd();
        real th, ph, mag;
        t_dq_cmd c;
        if ($urandom_range(9) < 3) begin
            c = {$urandom, $urandom};
        end else begin
            th = real'($urandom_range(65535)) * TWO_PI / 65536.0;
            ph = real'($urandom_range(65535)) * TWO_PI / 65536.0;
            mag = real'($urandom_range(40000));
            c.d_voltage = sat_q15(mag * $cos(ph));
            c.q_voltage = sat_q15(mag * $sin(ph));
            c.sine_value = sat_q15(32768.0 * $sin(th));
            c.cosine_value = sat_q15(32768.0 * $cos(th));
        end
        return c;
    endfunction

    task automatic check_field(string field, longint want, longint got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    task automatic wait_drained();
        repeat (2) @(posedge i_clk);
        while (!all_drained) @(posedge i_clk);
        repeat (LATENCY_SLACK) @(posedge i_clk);
    endtask

    task automatic write_period(logic [PER_W-1:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        period_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (cmd_taken) begin
            void'(cmd_backlog.pop_front());
            issued_count++;
            if (issued_count % 100 == 50) drain_hold = 1'b1;
        end
        if (drain_hold && duty_expected.size() == 0) drain_hold = 1'b0;
        if (!(start && !cmd_taken)) begin
            if (i_rst_n && !drain_hold && cmd_backlog.size() != 0
                    && $urandom_range(99) >= idle_pct) begin
                start <= 1'b1;
                i_cmd <= cmd_backlog[0];
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_duty_res want;
        cmd_taken <= i_rst_n && start && !busy;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) period_now <= i_cfg_data;
            if (start && !busy) begin
                duty_expected.push_back(predict_duty(i_cmd, period_now));
                accepted_count++;
            end
            if (o_done) begin
                if (duty_expected.size() == 0) begin
                    $display("%0t: result with no request pending, actual %p", $time, o_res);
                    mismatch_count++;
                end else begin
                    want = duty_expected.pop_front();
                    check_field("duty_a", want.duty_a, o_res.duty_a);
                    check_field("duty_b", want.duty_b, o_res.duty_b);
                    check_field("duty_c", want.duty_c, o_res.duty_c);
                    check_field("clipped", want.clipped, o_res.clipped);
                    result_count++;
                    if (want.clipped) clip_count++;
                end
            end
        end
        all_drained <= cmd_backlog.size() == 0 && !start && duty_expected.size() == 0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     cycle_count, duty_expected.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        logic [PER_W-1:0] phase_period[PHASE_COUNT];
        int phase_idle[PHASE_COUNT];
        int n_random;
        phase_period = '{PERIOD_RESET, 16'hffff, 16'd1, 16'd0,
                         PER_W'($urandom_range(65534, 2)), 16'd1000};
        phase_idle = '{0, 80, 0, 38, 80, 0};
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p > 0) begin
                wait_drained();
                write_period(phase_period[p]);
            end
            @(posedge i_clk);
            idle_pct = phase_idle[p];
            n_random = PHASE_ITEMS;
            if (p == 0) begin
                cmd_backlog.push_back(make_cmd(0, 0, 0, 0));
                cmd_backlog.push_back(make_cmd(32767, 0, 0, 32767));
                cmd_backlog.push_back(make_cmd(-32768, 0, 0, -32768));
                cmd_backlog.push_back(make_cmd(0, 32767, 32767, 0));
                cmd_backlog.push_back(make_cmd(0, -32768, -32768, 0));
                cmd_backlog.push_back(make_cmd(-32768, -32768, -32768, -32768));
                cmd_backlog.push_back(make_cmd(32767, 32767, 32767, 32767));
                cmd_backlog.push_back(make_cmd(32767, 32767, -32768, 32767));
                cmd_backlog.push_back(make_cmd(-32768, 32767, 32767, -32768));
                cmd_backlog.push_back(make_cmd(32767, -32768, 32767, 32767));
                cmd_backlog.push_back(make_cmd(0, 32767, 0, 32767));
                cmd_backlog.push_back(make_cmd(0, -32768, 0, -32768));
                cmd_backlog.push_back(make_cmd(1, 0, 0, 1));
                cmd_backlog.push_back(make_cmd(-1, 0, 0, 1));
                cmd_backlog.push_back(make_cmd(-1, -1, -1, -1));
                cmd_backlog.push_back(make_cmd(16384, 0, 0, 32767));
                cmd_backlog.push_back(make_cmd(18918, 0, 0, 32767));
                cmd_backlog.push_back(make_cmd(0, 18918, 0, 32767));
                cmd_backlog.push_back(make_cmd(23170, 23170, 23170, 23170));
                n_random = PHASE_ITEMS - cmd_backlog.size();
            end
            repeat (n_random) cmd_backlog.push_back(random_cmd());
        end
        wait_drained();
        $display("Summary: %0d requests over %0d period writes plus the reset period,",
                 accepted_count, period_writes);
        $display("         %0d results checked, %0d of them clipped, %0d mismatches.",
                 result_count, clip_count, mismatch_count);
        if (mismatch_count == 0 && duty_expected.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/dqsv_pkg.sv
sv/dqsv_front.sv
sv/dqsv_queue.sv
sv/dqsv_back.sv
sv/dq_to_svpwm_duty.sv
tb/tb_dq_to_svpwm_duty.sv
